[src/iatp_pkg.sv]
// iatp_pkg: shared types and constants for the IP address text parser.
// No dependencies.
`default_nettype none
package iatp_pkg;
  localparam logic [1:0] FAM_INVALID = 2'd0;
  localparam logic [1:0] FAM_IPV4    = 2'd1;
  localparam logic [1:0] FAM_IPV6    = 2'd2;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam int GROUPS = 8;
  localparam int MAX_GAP_GROUPS = 7;
  localparam int OCTETS = 4;
  localparam logic [8:0] OCTET_LIMIT = 9'd256;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [1:0]  family;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } result_t;
endpackage
`default_nettype wire

[src/iatp_char_fifo.sv]
// iatp_char_fifo: small queue between the character front end and the parser.
// Uses iatp_pkg.
`default_nettype none
module iatp_char_fifo (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    wr_en,
  input  iatp_pkg::char_item_t   wr_data,
  output logic                   full,
  input  wire                    rd_en,
  output iatp_pkg::char_item_t   rd_data,
  output logic                   empty
);
  import iatp_pkg::*;
  char_item_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign full  = (cnt_r == 3'd4);
  assign empty = (cnt_r == 3'd0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en && !full) wp_r <= wp_r + 2'd1;
      if (rd_en && !empty) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'((wr_en && !full) ? 1 : 0) - 3'((rd_en && !empty) ? 1 : 0);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("fifo count overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty && !(wr_en && !full) |=> empty)
    else $error("fifo empty changed without write");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    full && !rd_en |=> full)
    else $error("fifo full dropped without read");
endmodule
`default_nettype wire

[src/iatp_parser.sv]
// iatp_parser: per-character parsing state and final result assembly.
// Uses iatp_pkg.
`default_nettype none
module iatp_parser (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  input  iatp_pkg::char_item_t   in_item,
  output logic                   in_ready,
  output logic                   res_valid,
  output iatp_pkg::result_t      res,
  input  wire                    res_pop
);
  import iatp_pkg::*;

  logic [15:0] grp_r [8];
  logic [3:0]  gcnt_r;
  logic [2:0]  lcnt_r;
  logic        dcs_r, pcol_r;
  logic [15:0] hacc_r;
  logic [2:0]  dcnt_r;
  logic [8:0]  dacc_r;
  logic        alldec_r, lz_r;
  logic [7:0]  oct_r [3];
  logic [1:0]  oidx_r;
  logic        oidx_ovf;
  logic [1:0]  err_r;
  logic        rv_r;
  result_t     res_r;

  logic [15:0] grp_n [8];
  logic [3:0]  gcnt_n;
  logic [2:0]  lcnt_n;
  logic        dcs_n, pcol_n;
  logic [15:0] hacc_n;
  logic [2:0]  dcnt_n;
  logic [8:0]  dacc_n;
  logic        alldec_n, lz_n;
  logic [7:0]  oct_n [3];
  logic [1:0]  oidx_n;
  logic [1:0]  err_n;
  logic [4:0]  v;
  logic        is_hex, is_dec, tok_oct, tok_cur, fire;
  logic [12:0] prod;
  logic [15:0] seq [10];
  logic [3:0]  total;
  logic        ok;
  logic [15:0] words [8];
  logic [3:0]  right_n;
  result_t     res_n;

  assign oidx_ovf = 1'b0;
  // only a last character needs the result register; others pass while it waits
  assign in_ready = !rv_r || res_pop || !in_item.last;
  assign fire = in_valid && in_ready;
  assign res_valid = rv_r;
  assign res = res_r;

  always_comb begin
    logic [7:0] c;
    c = in_item.text_char;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    is_hex = !v[4];
    is_dec = is_hex && (v < 5'd10);
  end

  assign tok_cur = dcnt_r != 3'd0 && alldec_r && dacc_r < OCTET_LIMIT &&
                   !(lz_r && dcnt_r > 3'd1);

  always_comb begin
    grp_n = grp_r; gcnt_n = gcnt_r; lcnt_n = lcnt_r; dcs_n = dcs_r; pcol_n = pcol_r;
    hacc_n = hacc_r; dcnt_n = dcnt_r; dacc_n = dacc_r; alldec_n = alldec_r;
    lz_n = lz_r; oct_n = oct_r; oidx_n = oidx_r; err_n = err_r;
    prod = 13'(dacc_r) * 13'd10 + 13'(v[3:0]);
    if (is_hex) begin
      if (pcol_r && gcnt_r == 4'd0) err_n[1] = 1'b1;
      if (oidx_r != 2'd0 && !is_dec) err_n = 2'b11;
      if (dcnt_r < 3'd4) hacc_n = {hacc_r[11:0], v[3:0]};
      else err_n[1] = 1'b1;
      if (is_dec) begin
        if (dcnt_r == 3'd0 && v == 5'd0) lz_n = 1'b1;
        dacc_n = (prod > 13'(OCTET_LIMIT)) ? OCTET_LIMIT : prod[8:0];
      end else begin
        alldec_n = 1'b0;
        err_n[0] = 1'b1;
      end
      if (dcnt_r < 3'd7) dcnt_n = dcnt_r + 3'd1;
      pcol_n = 1'b0;
    end else if (in_item.text_char == CH_COLON) begin
      err_n[0] = 1'b1;
      if (oidx_r != 2'd0) err_n[1] = 1'b1;
      if (pcol_r) begin
        if (dcs_r || gcnt_r > 4'(MAX_GAP_GROUPS)) err_n[1] = 1'b1;
        else begin
          dcs_n = 1'b1;
          lcnt_n = gcnt_r[2:0];
        end
        pcol_n = 1'b0;
      end else if (dcnt_r == 3'd0) begin
        if (gcnt_r == 4'd0 && !dcs_r) pcol_n = 1'b1;
        else err_n[1] = 1'b1;
      end else begin
        if (gcnt_r < 4'(GROUPS)) begin
          grp_n[gcnt_r[2:0]] = hacc_r;
          gcnt_n = gcnt_r + 4'd1;
        end else err_n[1] = 1'b1;
        hacc_n = '0; dcnt_n = '0; dacc_n = '0; alldec_n = 1'b1; lz_n = 1'b0;
        pcol_n = 1'b1;
      end
    end else if (in_item.text_char == CH_DOT) begin
      if (dcnt_r == 3'd0 || oidx_r == 2'd3 || !tok_cur) err_n = 2'b11;
      else begin
        oct_n[oidx_r] = dacc_r[7:0];
        oidx_n = oidx_r + 2'd1;
      end
      hacc_n = '0; dcnt_n = '0; dacc_n = '0; alldec_n = 1'b1; lz_n = 1'b0;
      pcol_n = 1'b0;
    end else begin
      err_n = 2'b11;
    end
  end

  always_comb begin
    tok_oct = dcnt_n != 3'd0 && alldec_n && dacc_n < OCTET_LIMIT && !(lz_n && dcnt_n > 3'd1);
  end

  always_comb begin
    res_n = '{family: FAM_INVALID, addr_high: '0, addr_low: '0};
    for (int i = 0; i < 10; i++) seq[i] = '0;
    for (int i = 0; i < 8; i++) words[i] = '0;
    total = '0; ok = 1'b1; right_n = '0;
    if (!err_n[0] && oidx_n == 2'd3 && tok_oct && !oidx_ovf) begin
      res_n.family = FAM_IPV4;
      res_n.addr_low = {32'd0, oct_n[0], oct_n[1], oct_n[2], dacc_n[7:0]};
    end else if (!err_n[1]) begin
      for (int i = 0; i < 8; i++) seq[i] = grp_n[i];
      total = gcnt_n;
      if (oidx_n != 2'd0) begin
        if (oidx_n == 2'd3 && tok_oct) begin
          seq[gcnt_n] = {oct_n[0], oct_n[1]};
          seq[gcnt_n + 4'd1] = {oct_n[2], dacc_n[7:0]};
          total = gcnt_n + 4'd2;
        end else ok = 1'b0;
      end else if (pcol_n) ok = 1'b0;
      else if (dcnt_n != 3'd0) begin
        seq[gcnt_n] = hacc_n;
        total = gcnt_n + 4'd1;
      end
      if (dcs_n ? total > 4'(MAX_GAP_GROUPS) : total != 4'(GROUPS)) ok = 1'b0;
      if (dcs_n && 4'(lcnt_n) > total) ok = 1'b0;
      if (ok) begin
        if (dcs_n) begin
          right_n = total - 4'(lcnt_n);
          for (int i = 0; i < 8; i++) begin
            if (4'(i) < 4'(lcnt_n)) words[i] = seq[i];
            else if (4'(i) >= 4'd8 - right_n)
              words[i] = seq[4'(lcnt_n) + 4'(i) - (4'd8 - right_n)];
          end
        end else begin
          for (int i = 0; i < 8; i++) words[i] = seq[i];
        end
        res_n.family = FAM_IPV6;
        res_n.addr_high = {words[0], words[1], words[2], words[3]};
        res_n.addr_low  = {words[4], words[5], words[6], words[7]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (in_item.last) begin
        for (int i = 0; i < 8; i++) grp_r[i] <= '0;
        for (int i = 0; i < 3; i++) oct_r[i] <= '0;
        res_r <= res_n;
      end else begin
        grp_r <= grp_n;
        oct_r <= oct_n;
      end
    end
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) grp_r[i] <= '0;
      for (int i = 0; i < 3; i++) oct_r[i] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gcnt_r <= '0; lcnt_r <= '0; dcs_r <= 1'b0; pcol_r <= 1'b0; hacc_r <= '0;
      dcnt_r <= '0; dacc_r <= '0; alldec_r <= 1'b1; lz_r <= 1'b0; oidx_r <= '0;
      err_r <= '0; rv_r <= 1'b0;
    end else begin
      if (res_pop && rv_r) rv_r <= 1'b0;
      if (fire) begin
        if (in_item.last) begin
          gcnt_r <= '0; lcnt_r <= '0; dcs_r <= 1'b0; pcol_r <= 1'b0; hacc_r <= '0;
          dcnt_r <= '0; dacc_r <= '0; alldec_r <= 1'b1; lz_r <= 1'b0; oidx_r <= '0;
          err_r <= '0; rv_r <= 1'b1;
        end else begin
          gcnt_r <= gcnt_n; lcnt_r <= lcnt_n; dcs_r <= dcs_n; pcol_r <= pcol_n;
          hacc_r <= hacc_n; dcnt_r <= dcnt_n; dacc_r <= dacc_n; alldec_r <= alldec_n;
          lz_r <= lz_n; oidx_r <= oidx_n; err_r <= err_n;
        end
      end
    end
  end

  a_gcnt: assert property (@(posedge clk) disable iff (!rst_n) gcnt_r <= 4'd8)
    else $error("group count beyond eight");
  a_dacc: assert property (@(posedge clk) disable iff (!rst_n) dacc_r <= OCTET_LIMIT)
    else $error("decimal accumulator beyond limit");
  a_fam: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r && res_r.family != FAM_IPV6 |-> res_r.addr_high == 64'd0)
    else $error("nonzero high half outside IPv6");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rv_r && !res_pop |=> rv_r && $stable(res_r))
    else $error("pending result lost");
endmodule
`default_nettype wire

[src/ip_address_text_parser.sv]
// ip_address_text_parser: top level, character queue plus parser back end.
// Uses iatp_pkg, iatp_char_fifo, iatp_parser.
//
// Usage: push one text character per item on in_text_char with in_last on
// the final character; the item is taken when in_push is high and in_full
// low. Every text yields exactly one result, offered while out_empty is low
// and taken with out_pop. Results: out_family (0 invalid, 1 IPv4, 2 IPv6),
// out_addr_high and out_addr_low.
// Throughput: one character per cycle, sustained, except while a result
// waits unpopped and the next text's last character reaches the parser.
// The last character is first written into the queue; the parser step then
// registers the result, out_empty falls and the result can be popped.
// A four-entry character queue decouples input from the parser; while a
// result waits unpopped, the parser keeps one result register and stops
// only on the next text's last character, so the queue fills then in_full
// rises. Reset (rst_n low, synchronous) empties the queue and clears all
// parse state and the pending result.
`default_nettype none
module ip_address_text_parser (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_push,
  output logic        in_full,
  input  wire  [7:0]  in_text_char,
  input  wire         in_last,
  output logic        out_empty,
  input  wire         out_pop,
  output logic [1:0]  out_family,
  output logic [63:0] out_addr_high,
  output logic [63:0] out_addr_low
);
  import iatp_pkg::*;
  char_item_t q_in, q_out;
  logic q_empty, p_ready, r_valid;
  result_t r;

  assign q_in = '{text_char: in_text_char, last: in_last};

  iatp_char_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(in_push), .wr_data(q_in), .full(in_full),
    .rd_en(p_ready), .rd_data(q_out), .empty(q_empty)
  );

  iatp_parser u_parser (
    .clk(clk), .rst_n(rst_n), .in_valid(!q_empty), .in_item(q_out), .in_ready(p_ready),
    .res_valid(r_valid), .res(r), .res_pop(out_pop)
  );

  assign out_empty = !r_valid;
  assign out_family = r.family;
  assign out_addr_high = r.addr_high;
  assign out_addr_low = r.addr_low;
endmodule
`default_nettype wire

[sim/tb.sv]
// tb: self-checking testbench for ip_address_text_parser.
// Drives address texts one character per item and checks each parse result
// against an in-bench parser model. Depends on iatp_pkg and the RTL only.
`timescale 1ns / 100ps

class addr_scoreboard;
  logic [15:0] grp[8];
  int unsigned grp_n, left_n, hex_n, dig_n, dec_acc, oct_n;
  bit dbl, prev_colon, all_dec, lead_zero, v4_dead, v6_dead;
  logic [7:0] oct[4];
  iatp_pkg::result_t pending[$];
  int errors;

  function new();
    errors = 0;
    clear_all();
  endfunction

  function void clear_token();
    hex_n = 0; dig_n = 0; dec_acc = 0; all_dec = 1; lead_zero = 0;
  endfunction

  function void clear_all();
    foreach (grp[i]) grp[i] = '0;
    foreach (oct[i]) oct[i] = '0;
    grp_n = 0; left_n = 0; dbl = 0; prev_colon = 0; oct_n = 0;
    v4_dead = 0; v6_dead = 0;
    clear_token();
  endfunction

  function bit is_octet();
    return dig_n >= 1 && all_dec && dec_acc < 256 && !(lead_zero && dig_n > 1);
  endfunction

  function void note_char(logic [7:0] c, logic lst);
    int unsigned v, total, right, a;
    logic [15:0] seq[10];
    logic [15:0] words[8];
    bit ok;
    iatp_pkg::result_t r;
    if (c >= "0" && c <= "9") v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 10;
    else if (c >= "A" && c <= "F") v = c - "A" + 10;
    else v = 16;
    if (v < 16) begin
      if (prev_colon && grp_n == 0) v6_dead = 1;
      if (oct_n > 0 && v >= 10) begin v4_dead = 1; v6_dead = 1; end
      if (dig_n < 4) hex_n = ((hex_n << 4) | v) & 16'hffff;
      else v6_dead = 1;
      if (v < 10) begin
        if (dig_n == 0 && v == 0) lead_zero = 1;
        a = dec_acc * 10 + v;
        dec_acc = a > 256 ? 256 : a;
      end else begin
        all_dec = 0; v4_dead = 1;
      end
      if (dig_n < 7) dig_n++;
      prev_colon = 0;
    end else if (c == iatp_pkg::CH_COLON) begin
      v4_dead = 1;
      if (oct_n > 0) v6_dead = 1;
      if (prev_colon) begin
        if (dbl || grp_n > 7) v6_dead = 1;
        else begin dbl = 1; left_n = grp_n; end
        prev_colon = 0;
      end else if (dig_n == 0) begin
        if (grp_n == 0 && !dbl) prev_colon = 1;
        else v6_dead = 1;
      end else begin
        if (grp_n < 8) begin grp[grp_n] = hex_n[15:0]; grp_n++; end
        else v6_dead = 1;
        clear_token();
        prev_colon = 1;
      end
    end else if (c == iatp_pkg::CH_DOT) begin
      if (dig_n == 0 || oct_n >= 3 || !is_octet()) begin v4_dead = 1; v6_dead = 1; end
      else begin oct[oct_n] = dec_acc[7:0]; oct_n++; end
      clear_token();
      prev_colon = 0;
    end else begin
      v4_dead = 1; v6_dead = 1;
    end
    if (!lst) return;
    r = '0;
    r.family = iatp_pkg::FAM_INVALID;
    if (!v4_dead && oct_n == 3 && is_octet()) begin
      r.family = iatp_pkg::FAM_IPV4;
      r.addr_low = {32'd0, oct[0], oct[1], oct[2], dec_acc[7:0]};
    end else if (!v6_dead) begin
      total = 0; ok = 1;
      for (int i = 0; i < grp_n && i < 8; i++) begin seq[total] = grp[i]; total++; end
      if (oct_n > 0) begin
        if (oct_n == 3 && is_octet()) begin
          seq[total] = {oct[0], oct[1]}; total++;
          seq[total] = {oct[2], dec_acc[7:0]}; total++;
        end else ok = 0;
      end else if (prev_colon) ok = 0;
      else if (dig_n > 0) begin seq[total] = hex_n[15:0]; total++; end
      if (ok && (dbl ? total > 7 : total != 8)) ok = 0;
      if (ok && dbl && left_n > total) ok = 0;
      if (ok) begin
        foreach (words[i]) words[i] = '0;
        if (dbl) begin
          right = total - left_n;
          for (int i = 0; i < left_n; i++) words[i] = seq[i];
          for (int i = 0; i < right; i++) words[8 - right + i] = seq[left_n + i];
        end else
          for (int i = 0; i < 8; i++) words[i] = seq[i];
        r.addr_high = {words[0], words[1], words[2], words[3]};
        r.addr_low = {words[4], words[5], words[6], words[7]};
        r.family = iatp_pkg::FAM_IPV6;
      end
    end
    pending.push_back(r);
    clear_all();
  endfunction

  function void report(string what, logic [63:0] got, logic [63:0] want);
    $display("bad %s: got %h want %h", what, got, want);
    errors++;
  endfunction

  function void check_result(iatp_pkg::result_t got);
    iatp_pkg::result_t want;
    if (pending.size() == 0) begin
      report("unexpected result", got.family, 0);
      return;
    end
    want = pending.pop_front();
    if (got.family !== want.family) report("family", got.family, want.family);
    if (got.addr_high !== want.addr_high) report("addr_high", got.addr_high, want.addr_high);
    if (got.addr_low !== want.addr_low) report("addr_low", got.addr_low, want.addr_low);
  endfunction
endclass

module tb;
  logic clk, rst_n, in_push, in_full, in_last, out_empty, out_pop;
  logic [7:0] in_text_char;
  logic [1:0] out_family;
  logic [63:0] out_addr_high, out_addr_low;
  int send_idle, recv_idle, cycles, chars_sent;
  bit hold_off;
  addr_scoreboard sb;

  ip_address_text_parser dut (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("ip_address_text_parser: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && !out_empty && out_pop)
      sb.check_result('{out_family, out_addr_high, out_addr_low});
    if (rst_n && in_push && !in_full) sb.note_char(in_text_char, in_last);
    out_pop <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  task automatic send_char(byte c, bit lst);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1;
    in_text_char <= c;
    in_last <= lst;
    @(posedge clk);
    while (in_full) @(posedge clk);
    chars_sent++;
  endtask

  task automatic end_input();
    in_push <= 0;
    @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  function automatic string hex_group();
    string s;
    int n;
    s = "";
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) s = {s, $sformatf("%0h", $urandom_range(15))};
    if ($urandom_range(1)) s = s.toupper();
    return s;
  endfunction

  function automatic string v4_text();
    int w;
    w = $urandom_range(3);
    return $sformatf("%0d.%0d.%0d.%0d", w == 0 ? 255 : $urandom_range(255),
                     $urandom_range(255), w == 1 ? 0 : $urandom_range(255),
                     $urandom_range(255));
  endfunction

  function automatic string v6_text();
    string s;
    int n, gap, tail;
    tail = $urandom_range(3) == 0;
    s = "";
    if ($urandom_range(1)) begin
      n = 8 - 2 * tail;
      for (int i = 0; i < n; i++) s = {s, i ? ":" : "", hex_group()};
    end else begin
      n = $urandom_range(0, 7 - 2 * tail);
      gap = $urandom_range(0, n);
      for (int i = 0; i < n; i++) begin
        if (i == gap) s = {s, "::"};
        else if (i) s = {s, ":"};
        s = {s, hex_group()};
      end
      if (gap == n) s = {s, "::"};
    end
    if (tail) s = {s, (s.len() && s[s.len() - 1] != ":") ? ":" : "", v4_text()};
    return s;
  endfunction

  function automatic string mangle(string s);
    int p;
    if (s.len() == 0) return "x";
    p = $urandom_range(s.len() - 1);
    case ($urandom_range(3))
      0: s[p] = $urandom_range(255);
      1: s[p] = ":";
      2: s[p] = ".";
      default: s = {s.substr(0, p), s.substr(p, s.len() - 1)};
    endcase
    return s;
  endfunction

  task automatic random_texts(int chars);
    string s;
    int k, n;
    int target;
    target = chars_sent + chars;
    while (chars_sent < target) begin
      k = $urandom_range(9);
      if (k < 4) s = v6_text();
      else if (k < 7) s = v4_text();
      else if (k < 9) s = mangle($urandom_range(1) ? v6_text() : v4_text());
      else begin
        n = $urandom_range(1, 12);
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(255)))};
      end
      send_text(s);
    end
    end_input();
  endtask

  initial begin
    sb = new();
    rst_n = 0; in_push = 0; in_text_char = 0; in_last = 0; out_pop = 0;
    cycles = 0; chars_sent = 0; hold_off = 0;
    send_idle = 31; recv_idle = 80;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_text("0.0.0.0");
    send_text("255.255.255.255");
    send_text("256.1.1.1");
    send_text("01.2.3.4");
    send_text("1.2.3");
    send_text("1.2.3.4.5");
    send_text("ffff:FFFF:0:0:0:0:0:ffff");
    send_text("::");
    send_text("::1");
    send_text("1::");
    send_text("a:b::c:1.2.3.4");
    send_text("::ffff:10.0.0.1");
    send_text("1.2.3.4::");
    send_text(":1:2:3:4:5:6:7");
    send_text("1:2:3:4:5:6:7:");
    send_text(":::1");
    send_text("1::2::3");
    send_text("12345::");
    send_text("1:2:3:4:5:6:7:8:9");
    send_text("1:2:3:4:5:6:7::8");
    send_text("1.2:3.4");
    send_char("1", 0);
    send_char(".", 0);
    send_char("2", 0);
    send_char(8'h00, 0);
    send_char(".", 0);
    send_char("3", 0);
    send_char(".", 0);
    send_char("4", 1);
    send_char(8'h80, 1);
    send_char("g", 1);
    send_text("1111111111111111111111.2");
    fork
      begin
        repeat (30) @(posedge clk);
        hold_off <= 1;
        repeat (150) @(posedge clk);
        hold_off <= 0;
      end
      random_texts(335);
    join
    send_idle = 80; recv_idle = 31;
    random_texts(335);
    send_idle = 0; recv_idle = 0;
    random_texts(335);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("ip_address_text_parser: match");
    else $display("ip_address_text_parser: mismatch");
    $finish;
  end
endmodule

[ip_address_text_parser.f]
src/iatp_pkg.sv
src/iatp_char_fifo.sv
src/iatp_parser.sv
src/ip_address_text_parser.sv
sim/tb.sv
